// ===== hdl/pvm_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, opcodes and the voice entry layout for the voice mixer.
// No dependencies.
package pvm_pkg;

  localparam int VOICE_COUNT  = 9;
  localparam int CLIP_SLOTS   = 16;
  localparam int STORE_FRAMES = 16384;

  localparam int ADDR_W    = $clog2(STORE_FRAMES);
  localparam int CLIP_W    = 4;
  localparam int LEN_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int FRAME_W   = 2 * SAMPLE_W;
  localparam int SEQ_W     = 64;
  localparam int VIDX_W    = $clog2(VOICE_COUNT);
  localparam int ONESHOTS  = VOICE_COUNT - 1;
  localparam int OS_W      = (ONESHOTS > 1) ? $clog2(ONESHOTS) : 1;
  localparam int LOOP_VOICE = VOICE_COUNT - 1;
  localparam int REPORT_W  = 9;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_DEFINE = 3'd1,
    OP_PLAY   = 3'd2,
    OP_LOOP   = 3'd3,
    OP_MIX    = 3'd4
  } op_t;

  typedef struct packed {
    logic [CLIP_W-1:0] clip;
    logic              looping;
    logic [LEN_W-1:0]  cursor;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

endpackage

// ===== hdl/pvm_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/polyphonic_voice_mixer.sv =====
`timescale 1ns / 1ps
// Nine-voice stereo sample mixer: sample memory, voice state memory, control.
// Depends on pvm_pkg and pvm_ram.
//
// Channel  Dir  Signals                 Contents
// s_*      in   s_tvalid/s_tready/s_tdata  one command word
// m_*      out  m_tvalid/m_tready/m_tdata  one mixed frame, on a mix only
//
// Load, define and a play with a free one-shot voice end in S_IDLE; else play
// steals the oldest via S_PLAY_SCAN (one start number compared per cycle) and
// S_PLAY_ALLOC. Enabling a loop uses S_LOOP_WR. A mix runs S_MIX_RD and
// S_MIX_VOICE per voice (voice memory entry), plus S_MIX_ACC per voice with a
// sample (sample memory frame), then S_MIX_OUT. Reset is synchronous and takes
// effect at once; no clearing pass. A mix result waits in the output register
// while m_tready is low, and the next mix stalls only in S_MIX_OUT.
module polyphonic_voice_mixer
  import pvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[2:0] address[16:3] left_in[32:17] right_in[48:33] clip_index[52:49]
  // clip_start[66:53] clip_frames[81:67] loop_enable[82], zero fill
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_out[15:0] right_out[31:16] voices_active[40:32], zero fill
  output logic [47:0] m_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_PLAY_SCAN, S_PLAY_ALLOC, S_LOOP_WR,
    S_MIX_RD, S_MIX_VOICE, S_MIX_ACC, S_MIX_OUT
  } state_t;

  state_t state;

  // input word fields
  logic [2:0]          in_op;
  logic [ADDR_W-1:0]   in_addr;
  logic [SAMPLE_W-1:0] in_left, in_right;
  logic [CLIP_W-1:0]   in_clip;
  logic [ADDR_W-1:0]   in_start;
  logic [LEN_W-1:0]    in_frames;
  logic                in_enable;

  assign in_op     = s_tdata[2:0];
  assign in_addr   = s_tdata[16:3];
  assign in_left   = s_tdata[32:17];
  assign in_right  = s_tdata[48:33];
  assign in_clip   = s_tdata[52:49];
  assign in_start  = s_tdata[66:53];
  assign in_frames = s_tdata[81:67];
  assign in_enable = s_tdata[82];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // state registers
  logic [ADDR_W-1:0]  clip_start_tab [CLIP_SLOTS];
  logic [LEN_W-1:0]   clip_len_tab   [CLIP_SLOTS];
  logic [VOICE_COUNT-1:0] active;
  logic [VOICE_COUNT-1:0] vvalid;
  logic [SEQ_W-1:0]   start_num [ONESHOTS];
  logic [SEQ_W-1:0]   play_count;
  logic               loop_clip_valid;
  logic [CLIP_W-1:0]  looping_clip;

  // working registers
  logic [CLIP_W-1:0]   clip_q;
  logic [VIDX_W-1:0]   vidx;
  logic [OS_W-1:0]     scan;
  logic [OS_W-1:0]     chosen;
  logic                found;
  logic [SEQ_W-1:0]    oldest;
  logic [SAMPLE_W-1:0] acc_l, acc_r;

  // memories
  logic                sram_we;
  logic [ADDR_W-1:0]   sram_raddr;
  logic [FRAME_W-1:0]  sram_rdata;
  logic                vram_we;
  logic [VIDX_W-1:0]   vram_waddr, vram_raddr;
  voice_t              vram_wdata, vram_rdata;
  logic [VOICE_W-1:0]  vram_rbits;

  pvm_ram #(.WIDTH(FRAME_W), .DEPTH(STORE_FRAMES)) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (in_addr),
    .wdata ({in_right, in_left}),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  pvm_ram #(.WIDTH(VOICE_W), .DEPTH(VOICE_COUNT)) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rbits)
  );

  assign vram_rdata = voice_t'(vram_rbits);

  // first free one-shot voice
  logic            any_free;
  logic [OS_W-1:0] first_free;
  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = ONESHOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        any_free   = 1'b1;
        first_free = OS_W'(i);
      end
    end
  end

  // voice under mix; an entry never written reads as reset
  voice_t             cur_v;
  logic [LEN_W-1:0]   v_len;
  logic [LEN_W-1:0]   cur_eff, cur_adv;
  logic               v_hit, v_finish, v_live;
  logic               last_voice;

  always_comb begin
    cur_v    = vvalid[vidx] ? vram_rdata : '0;
    v_len    = clip_len_tab[cur_v.clip];
    cur_eff  = (cur_v.cursor >= v_len && cur_v.looping) ? '0 : cur_v.cursor;
    v_hit    = cur_eff < v_len;
    cur_adv  = v_hit ? cur_eff + LEN_W'(1) : cur_eff;
    v_finish = (cur_adv >= v_len) && !cur_v.looping;
    v_live   = active[vidx] && (v_len != '0);
  end

  assign last_voice = (vidx == VIDX_W'(VOICE_COUNT - 1));
  assign sram_raddr = ADDR_W'(clip_start_tab[cur_v.clip] + cur_eff);
  assign sram_we    = accept && (in_op == OP_LOAD);

  logic play_ok, loop_ok;
  assign play_ok = (clip_len_tab[in_clip] != '0);
  assign loop_ok = (clip_len_tab[in_clip] != '0) &&
                   !(loop_clip_valid && looping_clip == in_clip && active[LOOP_VOICE]);

  always_comb begin
    vram_raddr = (state == S_MIX_RD) ? vidx : VIDX_W'(LOOP_VOICE);
    vram_we    = 1'b0;
    vram_waddr = vidx;
    vram_wdata = '0;
    case (state)
      S_IDLE: begin
        if (accept && in_op == OP_PLAY && play_ok && any_free) begin
          vram_we         = 1'b1;
          vram_waddr      = VIDX_W'(first_free);
          vram_wdata.clip = in_clip;
        end
      end
      S_PLAY_ALLOC: begin
        vram_we         = found;
        vram_waddr      = VIDX_W'(chosen);
        vram_wdata.clip = clip_q;
      end
      S_LOOP_WR: begin
        vram_we            = 1'b1;
        vram_waddr         = VIDX_W'(LOOP_VOICE);
        vram_wdata.clip    = clip_q;
        vram_wdata.looping = 1'b1;
        vram_wdata.cursor  = vvalid[LOOP_VOICE] ? vram_rdata.cursor : '0;
      end
      S_MIX_VOICE: begin
        vram_we            = v_live;
        vram_wdata.clip    = cur_v.clip;
        vram_wdata.looping = cur_v.looping;
        vram_wdata.cursor  = v_finish ? '0 : cur_adv;
      end
      default: ;
    endcase
  end

  function automatic logic [SAMPLE_W-1:0] sat_add(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      sat_add = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat_add = s[SAMPLE_W-1:0];
    end
  endfunction

  logic [REPORT_W-1:0] report;
  always_comb begin
    report = '0;
    for (int i = 0; i < REPORT_W; i++) begin
      if (i < VOICE_COUNT) report[i] = active[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      active          <= '0;
      vvalid          <= '0;
      play_count      <= '0;
      loop_clip_valid <= 1'b0;
      looping_clip    <= '0;
      m_tvalid        <= 1'b0;
      for (int i = 0; i < CLIP_SLOTS; i++) begin
        clip_start_tab[i] <= '0;
        clip_len_tab[i]   <= '0;
      end
      for (int i = 0; i < ONESHOTS; i++) begin
        start_num[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != S_MIX_OUT) m_tvalid <= 1'b0;
      if (vram_we) vvalid[vram_waddr] <= 1'b1;
      case (state)
        S_IDLE: begin
          clip_q <= in_clip;
          if (accept) begin
            case (op_t'(in_op))
              OP_DEFINE: begin
                clip_start_tab[in_clip] <= in_start;
                clip_len_tab[in_clip]   <= in_frames;
              end
              OP_PLAY: begin
                if (play_ok) begin
                  play_count <= play_count + SEQ_W'(1);
                  if (any_free) begin
                    active[first_free]    <= 1'b1;
                    start_num[first_free] <= play_count + SEQ_W'(1);
                  end else begin
                    scan   <= '0;
                    found  <= 1'b0;
                    oldest <= '1;
                    state  <= S_PLAY_SCAN;
                  end
                end
              end
              OP_LOOP: begin
                if (!in_enable) begin
                  active[LOOP_VOICE] <= 1'b0;
                end else if (loop_ok) begin
                  state <= S_LOOP_WR;
                end
              end
              OP_MIX: begin
                vidx  <= '0;
                acc_l <= '0;
                acc_r <= '0;
                state <= S_MIX_RD;
              end
              default: ;
            endcase
          end
        end
        S_PLAY_SCAN: begin
          if (start_num[scan] < oldest) begin
            oldest <= start_num[scan];
            chosen <= scan;
            found  <= 1'b1;
          end
          if (scan == OS_W'(ONESHOTS - 1)) begin
            state <= S_PLAY_ALLOC;
          end else begin
            scan <= scan + OS_W'(1);
          end
        end
        S_PLAY_ALLOC: begin
          if (found) begin
            active[chosen]    <= 1'b1;
            start_num[chosen] <= play_count;
          end
          state <= S_IDLE;
        end
        S_LOOP_WR: begin
          loop_clip_valid    <= 1'b1;
          looping_clip       <= clip_q;
          active[LOOP_VOICE] <= 1'b1;
          state              <= S_IDLE;
        end
        S_MIX_RD: begin
          state <= S_MIX_VOICE;
        end
        S_MIX_VOICE: begin
          if (active[vidx] && (v_len == '0 || v_finish)) begin
            active[vidx] <= 1'b0;
          end
          if (v_live && v_hit) begin
            state <= S_MIX_ACC;
          end else if (last_voice) begin
            state <= S_MIX_OUT;
          end else begin
            vidx  <= vidx + VIDX_W'(1);
            state <= S_MIX_RD;
          end
        end
        S_MIX_ACC: begin
          acc_l <= sat_add(acc_l, sram_rdata[SAMPLE_W-1:0]);
          acc_r <= sat_add(acc_r, sram_rdata[FRAME_W-1:SAMPLE_W]);
          if (last_voice) begin
            state <= S_MIX_OUT;
          end else begin
            vidx  <= vidx + VIDX_W'(1);
            state <= S_MIX_RD;
          end
        end
        S_MIX_OUT: begin
          // hold until the previous word has gone
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, report, acc_r, acc_l};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
